// File: hdl/cpd_pkg.sv
// Package for the checksummed packet deframer.
// Holds the phase and result-kind codes, register indexes and shared structs.
// No dependencies.
package cpd_pkg;

    // Header length in bytes: start, module id, command, length MSB, length LSB
    localparam int unsigned HDR_LEN = 5;

    localparam int unsigned CFG_INDEX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SYMBOL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_SYMBOL      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODULE_ID_MAX   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_CAPACITY = 3'd4;

    // Receive phase
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_FOOTER  = 2'd3
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        KIND_PROGRESS = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_DONE     = 2'd2,
        KIND_REJECT   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  start_symbol;
        logic [7:0]  end_symbol;
        logic [7:0]  module_id_max;
        logic [15:0] max_payload;
        logic [15:0] buffer_capacity;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [15:0] payload_index;
        logic [7:0]  module_id;
        logic [7:0]  command;
        logic [15:0] payload_length;
        logic        err_start;
        logic        err_module;
        logic        err_length;
        logic        err_checksum;
        logic        err_end;
        logic        err_overflow;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] byte_count;
    } status_t;

endpackage

// File: hdl/cpd_cfg_regs.sv
// Configuration register file of the packet deframer.
// Depends on cpd_pkg for register indexes and the cfg_t struct.
module cpd_cfg_regs
    import cpd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // Always take a write; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_symbol    <= 8'd1;
            cfg_reg.end_symbol      <= 8'd4;
            cfg_reg.module_id_max   <= 8'd255;
            cfg_reg.max_payload     <= 16'd1024;
            cfg_reg.buffer_capacity <= 16'd1032;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_SYMBOL:    cfg_reg.start_symbol    <= cfg_data[7:0];
                CFG_END_SYMBOL:      cfg_reg.end_symbol      <= cfg_data[7:0];
                CFG_MODULE_ID_MAX:   cfg_reg.module_id_max   <= cfg_data[7:0];
                CFG_MAX_PAYLOAD:     cfg_reg.max_payload     <= cfg_data;
                CFG_BUFFER_CAPACITY: cfg_reg.buffer_capacity <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/cpd_step.sv
// Packet state machine of the deframer: phase, counters, header fields and sum.
// Computes the result of one byte or flush. Depends on cpd_pkg.
module cpd_step
    import cpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        advance,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output result_t     result,
    output status_t     status
);

    phase_t      phase_reg,   phase_next;
    logic [15:0] count_reg,   count_next;
    logic [15:0] length_reg,  length_next;
    logic [7:0]  module_reg,  module_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] sum_reg,     sum_next;
    logic [15:0] rsum_reg,    rsum_next;

    logic [15:0] count_inc;
    logic [15:0] sum_add;
    logic [16:0] foot_base;
    logic [16:0] count_ext;
    logic [15:0] length_lo;

    assign count_inc = count_reg + 16'd1;
    assign sum_add   = sum_reg + {8'd0, rx_byte};
    assign count_ext = {1'b0, count_reg};
    assign foot_base = {1'b0, length_reg} + 17'(HDR_LEN);
    assign length_lo = {length_reg[15:8], rx_byte};

    assign status.phase      = phase_reg;
    assign status.byte_count = count_reg;

    // Hold state until the item moves on to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            length_reg  <= '0;
            module_reg  <= '0;
            command_reg <= '0;
            sum_reg     <= '0;
            rsum_reg    <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            module_reg  <= module_next;
            command_reg <= command_next;
            sum_reg     <= sum_next;
            rsum_reg    <= rsum_next;
        end
    end

    // Next state and result for the item in the input register
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        module_next  = module_reg;
        command_next = command_reg;
        sum_next     = sum_reg;
        rsum_next    = rsum_reg;
        result       = '0;
        result.kind  = KIND_PROGRESS;

        if (op) begin
            // Flush: back to hunting
            phase_next = PH_HUNT;
            count_next = '0;
        end else if (count_reg >= cfg.buffer_capacity) begin
            // No room (or no buffer): drop the byte
            result.kind         = KIND_REJECT;
            result.err_overflow = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte != cfg.start_symbol) begin
                        result.kind      = KIND_REJECT;
                        result.err_start = 1'b1;
                    end else begin
                        count_next = 16'd1;
                        sum_next   = {8'd0, rx_byte};
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    sum_next   = sum_add;
                    count_next = count_inc;
                    if (count_reg == 16'd1) begin
                        module_next = rx_byte;
                    end else if (count_reg == 16'd2) begin
                        command_next = rx_byte;
                    end else if (count_reg == 16'd3) begin
                        length_next = {rx_byte, length_reg[7:0]};
                    end else begin
                        length_next = length_lo;
                        phase_next  = (length_lo == 16'd0) ? PH_FOOTER : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    sum_next             = sum_add;
                    count_next           = count_inc;
                    result.kind          = KIND_PAYLOAD;
                    result.data_byte     = rx_byte;
                    result.payload_index = count_reg - 16'(HDR_LEN);
                    if (count_ext + 17'd1 >= foot_base) begin
                        phase_next = PH_FOOTER;
                    end
                end
                PH_FOOTER: begin
                    count_next = count_inc;
                    if (count_ext == foot_base) begin
                        rsum_next = {rx_byte, rsum_reg[7:0]};
                    end else if (count_ext == foot_base + 17'd1) begin
                        rsum_next = {rsum_reg[15:8], rx_byte};
                    end else begin
                        // Last byte: validate and report the packet
                        result.kind           = KIND_DONE;
                        result.module_id      = module_reg;
                        result.command        = command_reg;
                        result.payload_length = length_reg;
                        result.err_module     = module_reg > cfg.module_id_max;
                        result.err_length     = length_reg > cfg.max_payload;
                        result.err_checksum   = (16'd0 - sum_reg) != rsum_reg;
                        result.err_end        = rx_byte != cfg.end_symbol;
                        phase_next            = PH_HUNT;
                        count_next            = '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/checksummed_packet_deframer_core.sv
// Top level of the checksummed packet deframer: input register, step logic,
// result register. Depends on cpd_pkg, cpd_cfg_regs and cpd_step.
//
// Deframes packets of the form start symbol, module id, command, 16-bit
// big-endian length, payload, 16-bit two's-complement checksum, end symbol,
// one byte (or flush) per input transfer and exactly one result transfer per
// input transfer. Throughput is one item per clock while the result channel
// is not stalled; an item passes through the input register, then the result
// register, with the running sum, byte counter and phase updated in the step
// stage. Both stages advance together, so the block keeps taking bytes while
// a result waits, until both registers are full. Configuration writes are
// always taken and must only be issued while idle.
module checksummed_packet_deframer_core
    import cpd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic [7:0]             s_rx_byte,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_kind,
    output logic [7:0]             m_data_byte,
    output logic [15:0]            m_payload_index,
    output logic [7:0]             m_module_id,
    output logic [7:0]             m_command,
    output logic [15:0]            m_payload_length,
    output logic                   m_err_start,
    output logic                   m_err_module,
    output logic                   m_err_length,
    output logic                   m_err_checksum,
    output logic                   m_err_end,
    output logic                   m_err_overflow
);

    cfg_t    cfg;
    result_t step_result;
    status_t step_status;

    logic       in_valid_reg, in_valid_next;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       advance;
    logic       in_take;

    cpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .op      (in_op_reg),
        .rx_byte (in_byte_reg),
        .result  (step_result),
        .status  (step_status)
    );

    // Advance when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg   <= s_op;
            in_byte_reg <= s_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_data_byte      = out_reg.data_byte;
    assign m_payload_index  = out_reg.payload_index;
    assign m_module_id      = out_reg.module_id;
    assign m_command        = out_reg.command;
    assign m_payload_length = out_reg.payload_length;
    assign m_err_start      = out_reg.err_start;
    assign m_err_module     = out_reg.err_module;
    assign m_err_length     = out_reg.err_length;
    assign m_err_checksum   = out_reg.err_checksum;
    assign m_err_end        = out_reg.err_end;
    assign m_err_overflow   = out_reg.err_overflow;

    // A stalled input item is held in place
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_op_reg))
        else $error("input register changed while stalled");

    // A flush leaves the deframer hunting with an empty count
    a_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg |=> step_status.phase == PH_HUNT
            && step_status.byte_count == 16'd0)
        else $error("flush did not return to hunting");

    // A taken result with nothing behind it empties the result register
    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && m_ready && !advance |=> !out_valid_reg)
        else $error("result transfer repeated");

endmodule
